/* sv/ntt_pkg.sv */
// ----------------------------------------------------------------------------
// ntt_pkg
// Shared constants, codes and controller/datapath interface types for the
// forward NTT block.
// ----------------------------------------------------------------------------
package ntt_pkg;

  localparam int LOG_N_MAX = 10;
  localparam int COEF_AW   = LOG_N_MAX;
  localparam int ROOT_AW   = LOG_N_MAX - 1;
  localparam int WORD_W    = 30;

  localparam logic [1:0] OP_LOAD_COEF = 2'd0;
  localparam logic [1:0] OP_LOAD_ROOT = 2'd1;
  localparam logic [1:0] OP_START     = 2'd2;
  localparam logic [1:0] OP_READ      = 2'd3;

  localparam logic [1:0] CFG_MODULUS  = 2'd0;
  localparam logic [1:0] CFG_NEG_INV  = 2'd1;
  localparam logic [1:0] CFG_LOG_SIZE = 2'd2;

  localparam logic [1:0] WS_LOAD = 2'd0;
  localparam logic [1:0] WS_REM  = 2'd1;
  localparam logic [1:0] WS_SUM  = 2'd2;
  localparam logic [1:0] WS_DIFF = 2'd3;

  localparam logic [1:0] RS_COEF = 2'd0;
  localparam logic [1:0] RS_ROOT = 2'd1;
  localparam logic [1:0] RS_MONT = 2'd2;

  typedef struct packed {
    logic               coef_re;
    logic               coef_we;
    logic [COEF_AW-1:0] coef_addr;
    logic [1:0]         coef_wsel;
    logic               root_re;
    logic               root_we;
    logic [ROOT_AW-1:0] root_addr;
    logic               rem_go;
    logic [1:0]         rem_sel;
    logic               cap_w;
    logic               cap_v;
    logic               cap_u;
    logic               cap_t;
    logic               cap_out;
  } ntt_cmd_t;

  typedef struct packed {
    logic rem_done;
  } ntt_stat_t;

endpackage

/* sv/ntt_rem.sv */
// ----------------------------------------------------------------------------
// ntt_rem
// Bit-serial restoring remainder unit: x mod p, one quotient bit per cycle.
// With p zero it returns the low word bits of x.
// ----------------------------------------------------------------------------
module ntt_rem
  import ntt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  logic [WORD_W:0]   x,
  input  logic [WORD_W-1:0] p,
  output logic              done,
  output logic [WORD_W-1:0] res
);

  logic [WORD_W-1:0] acc;
  logic [WORD_W:0]   xs;
  logic [4:0]        cnt;
  logic              run;
  logic [WORD_W:0]   nr;

  assign nr  = {acc, xs[WORD_W]};
  assign res = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= 5'(WORD_W);
      end else if (run) begin
        cnt <= cnt - 5'd1;
        if (cnt == 5'd0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      acc <= '0;
      xs  <= x;
    end else if (run) begin
      xs <= {xs[WORD_W-1:0], 1'b0};
      if (nr >= {1'b0, p}) begin
        acc <= WORD_W'(nr - {1'b0, p});
      end else begin
        acc <= nr[WORD_W-1:0];
      end
    end
  end

endmodule

/* sv/ntt_dp.sv */
// ----------------------------------------------------------------------------
// ntt_dp
// Datapath: coefficient and root memories, Montgomery multiplier pipeline,
// shared remainder unit and modular add/subtract.
// ----------------------------------------------------------------------------
module ntt_dp
  import ntt_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  ntt_cmd_t          cmd,
  output ntt_stat_t         stat,
  input  logic [WORD_W-1:0] value,
  input  logic [WORD_W-1:0] modulus,
  input  logic [31:0]       mont_neg_inverse,
  output logic [WORD_W-1:0] out_value
);

  logic [WORD_W-1:0] coef_mem [2**COEF_AW];
  logic [WORD_W-1:0] root_mem [2**ROOT_AW];
  logic [WORD_W-1:0] cdata, rdata;
  logic [WORD_W-1:0] u, v, w, t;
  logic [59:0]       prod;
  logic [31:0]       m;
  logic [61:0]       mp;
  logic [32:0]       low;
  logic [WORD_W:0]   mont_r;
  logic [WORD_W:0]   rem_x;
  logic [WORD_W-1:0] rem_res;
  logic              rem_done;
  logic [WORD_W:0]   s1, d1;
  logic [WORD_W-1:0] sum, diff, wdata;

  always_ff @(posedge clk) begin
    if (cmd.coef_we) begin
      coef_mem[cmd.coef_addr] <= wdata;
    end
    if (cmd.coef_re) begin
      cdata <= coef_mem[cmd.coef_addr];
    end
    if (cmd.root_we) begin
      root_mem[cmd.root_addr] <= value;
    end
    if (cmd.root_re) begin
      rdata <= root_mem[cmd.root_addr];
    end
  end

  // montgomery pipeline, free running on held operands
  always_ff @(posedge clk) begin
    prod <= {30'b0, v} * {30'b0, w};
    m    <= prod[31:0] * mont_neg_inverse;
    mp   <= {30'b0, m} * {32'b0, modulus};
  end

  assign low    = {1'b0, prod[31:0]} + {1'b0, mp[31:0]};
  assign mont_r = {3'b0, prod[59:32]} + {1'b0, mp[61:32]} + {30'b0, low[32]};

  always_comb begin
    case (cmd.rem_sel)
      RS_COEF: rem_x = {1'b0, cdata};
      RS_ROOT: rem_x = {1'b0, rdata};
      RS_MONT: rem_x = mont_r;
      default: rem_x = {1'b0, cdata};
    endcase
  end

  ntt_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.rem_go),
    .x    (rem_x),
    .p    (modulus),
    .done (rem_done),
    .res  (rem_res)
  );

  assign stat.rem_done = rem_done;

  assign s1 = {1'b0, u} + {1'b0, t};
  assign d1 = {1'b0, u} + {1'b0, modulus} - {1'b0, t};

  always_comb begin
    if (modulus == '0) begin
      sum  = s1[WORD_W-1:0];
      diff = WORD_W'(u - t);
    end else begin
      sum  = (s1 >= {1'b0, modulus}) ? WORD_W'(s1 - {1'b0, modulus}) : s1[WORD_W-1:0];
      diff = (d1 >= {1'b0, modulus}) ? WORD_W'(d1 - {1'b0, modulus}) : d1[WORD_W-1:0];
    end
  end

  always_comb begin
    case (cmd.coef_wsel)
      WS_LOAD: wdata = value;
      WS_REM:  wdata = rem_res;
      WS_SUM:  wdata = sum;
      WS_DIFF: wdata = diff;
      default: wdata = value;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.cap_w) begin
      w <= rem_res;
    end
    if (cmd.cap_v) begin
      v <= cdata;
    end
    if (cmd.cap_u) begin
      u <= cdata;
    end
    if (cmd.cap_t) begin
      t <= rem_res;
    end
    if (cmd.cap_out) begin
      out_value <= rem_res;
    end
  end

endmodule

/* sv/ntt_ctrl.sv */
// ----------------------------------------------------------------------------
// ntt_ctrl
// Sequencer: decodes commands, runs the reduction pass and the butterfly
// schedule stage by stage, and raises the result strobe.
// ----------------------------------------------------------------------------
module ntt_ctrl
  import ntt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [1:0]         opcode,
  input  logic [COEF_AW-1:0] index,
  input  logic [3:0]         log_size,
  input  ntt_stat_t          stat,
  output ntt_cmd_t           cmd,
  output logic               busy,
  output logic               result_valid,
  output logic               kind
);

  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_RD_GO   = 5'd1;
  localparam logic [4:0] S_RD_RED  = 5'd2;
  localparam logic [4:0] S_RD_OUT  = 5'd3;
  localparam logic [4:0] S_PRE_RD  = 5'd4;
  localparam logic [4:0] S_PRE_GO  = 5'd5;
  localparam logic [4:0] S_PRE_RED = 5'd6;
  localparam logic [4:0] S_BF_RW   = 5'd7;
  localparam logic [4:0] S_BF_WGO  = 5'd8;
  localparam logic [4:0] S_BF_WRED = 5'd9;
  localparam logic [4:0] S_BF_RV   = 5'd10;
  localparam logic [4:0] S_BF_RU   = 5'd11;
  localparam logic [4:0] S_BF_GU   = 5'd12;
  localparam logic [4:0] S_BF_M1   = 5'd13;
  localparam logic [4:0] S_BF_M2   = 5'd14;
  localparam logic [4:0] S_BF_TGO  = 5'd15;
  localparam logic [4:0] S_BF_TRED = 5'd16;
  localparam logic [4:0] S_BF_WU   = 5'd17;
  localparam logic [4:0] S_BF_WV   = 5'd18;
  localparam logic [4:0] S_DONE    = 5'd19;

  logic [4:0]         state, state_next;
  logic [COEF_AW-1:0] j, j_next;
  logic [ROOT_AW-1:0] i, i_next;
  logic [3:0]         s, s_next;
  logic [3:0]         lg;
  logic [COEF_AW-1:0] nm1;
  logic [ROOT_AW-1:0] hm1;
  logic [ROOT_AW-1:0] off, k;
  logic [COEF_AW-1:0] pu, pv;

  assign lg  = (log_size > 4'(LOG_N_MAX)) ? 4'(LOG_N_MAX) : log_size;
  assign nm1 = COEF_AW'(({1'b0, {COEF_AW{1'b0}}} | (COEF_AW+1)'(1) << lg) - (COEF_AW+1)'(1));
  assign hm1 = ROOT_AW'(((COEF_AW)'(1) << (lg - 4'd1)) - COEF_AW'(1));
  assign off = i & ROOT_AW'((COEF_AW'(1) << s) - COEF_AW'(1));
  assign k   = i >> s;
  assign pu  = (COEF_AW'(k) << (s + 4'd1)) | COEF_AW'(off);
  assign pv  = pu | (COEF_AW'(1) << s);

  assign busy         = (state != S_IDLE);
  assign result_valid = (state == S_RD_OUT) || (state == S_DONE);
  assign kind         = (state == S_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      j     <= '0;
      i     <= '0;
      s     <= '0;
    end else begin
      state <= state_next;
      j     <= j_next;
      i     <= i_next;
      s     <= s_next;
    end
  end

  always_comb begin
    state_next = state;
    j_next     = j;
    i_next     = i;
    s_next     = s;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        cmd.coef_addr = index;
        cmd.root_addr = index[ROOT_AW-1:0];
        cmd.coef_wsel = WS_LOAD;
        if (start) begin
          case (opcode)
            OP_LOAD_COEF: cmd.coef_we = 1'b1;
            OP_LOAD_ROOT: cmd.root_we = 1'b1;
            OP_START: begin
              j_next     = '0;
              state_next = S_PRE_RD;
            end
            OP_READ: begin
              cmd.coef_re = 1'b1;
              state_next  = S_RD_GO;
            end
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_RD_GO: begin
        cmd.rem_go  = 1'b1;
        cmd.rem_sel = RS_COEF;
        state_next  = S_RD_RED;
      end
      S_RD_RED: begin
        if (stat.rem_done) begin
          cmd.cap_out = 1'b1;
          state_next  = S_RD_OUT;
        end
      end
      S_RD_OUT: state_next = S_IDLE;
      S_PRE_RD: begin
        cmd.coef_re   = 1'b1;
        cmd.coef_addr = j;
        state_next    = S_PRE_GO;
      end
      S_PRE_GO: begin
        cmd.rem_go  = 1'b1;
        cmd.rem_sel = RS_COEF;
        state_next  = S_PRE_RED;
      end
      S_PRE_RED: begin
        cmd.coef_addr = j;
        cmd.coef_wsel = WS_REM;
        if (stat.rem_done) begin
          cmd.coef_we = 1'b1;
          j_next      = j + COEF_AW'(1);
          if (j != nm1) begin
            state_next = S_PRE_RD;
          end else if (lg == 4'd0) begin
            state_next = S_DONE;
          end else begin
            s_next     = lg - 4'd1;
            i_next     = '0;
            state_next = S_BF_RW;
          end
        end
      end
      S_BF_RW: begin
        cmd.root_re   = 1'b1;
        cmd.root_addr = k;
        state_next    = S_BF_WGO;
      end
      S_BF_WGO: begin
        cmd.rem_go  = 1'b1;
        cmd.rem_sel = RS_ROOT;
        state_next  = S_BF_WRED;
      end
      S_BF_WRED: begin
        if (stat.rem_done) begin
          cmd.cap_w  = 1'b1;
          state_next = S_BF_RV;
        end
      end
      S_BF_RV: begin
        cmd.coef_re   = 1'b1;
        cmd.coef_addr = pv;
        state_next    = S_BF_RU;
      end
      S_BF_RU: begin
        cmd.cap_v     = 1'b1;
        cmd.coef_re   = 1'b1;
        cmd.coef_addr = pu;
        state_next    = S_BF_GU;
      end
      S_BF_GU: begin
        cmd.cap_u  = 1'b1;
        state_next = S_BF_M1;
      end
      S_BF_M1: state_next = S_BF_M2;
      S_BF_M2: state_next = S_BF_TGO;
      S_BF_TGO: begin
        cmd.rem_go  = 1'b1;
        cmd.rem_sel = RS_MONT;
        state_next  = S_BF_TRED;
      end
      S_BF_TRED: begin
        if (stat.rem_done) begin
          cmd.cap_t  = 1'b1;
          state_next = S_BF_WU;
        end
      end
      S_BF_WU: begin
        cmd.coef_we   = 1'b1;
        cmd.coef_addr = pu;
        cmd.coef_wsel = WS_SUM;
        state_next    = S_BF_WV;
      end
      S_BF_WV: begin
        cmd.coef_we   = 1'b1;
        cmd.coef_addr = pv;
        cmd.coef_wsel = WS_DIFF;
        i_next        = i + ROOT_AW'(1);
        state_next    = S_BF_RW;
        if (i == hm1) begin
          i_next = '0;
          if (s == 4'd0) begin
            state_next = S_DONE;
          end else begin
            s_next = s - 4'd1;
          end
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/ntt_forward_dif_montgomery.sv */
// ----------------------------------------------------------------------------
// ntt_forward_dif_montgomery
// Loads keep busy low, so one word per cycle streams in while no read or start is running.
// A read passes its word through the 31-step remainder unit before returning it.
// A start strobes its done word once every coefficient is reduced and every butterfly
// is done, both paced by the serial remainder unit.
// Results are strobed for one cycle; the receiver cannot stall.
// Synchronous reset clears control and restores register defaults; memories hold no reset.
// ----------------------------------------------------------------------------
module ntt_forward_dif_montgomery
  import ntt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         opcode,
  input  logic [COEF_AW-1:0] index,
  input  logic [WORD_W-1:0]  value,
  output logic               result_valid,
  output logic               kind,
  output logic [WORD_W-1:0]  read_value,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [31:0]        cfg_data
);

  logic [WORD_W-1:0] modulus;
  logic [31:0]       mont_neg_inverse;
  logic [3:0]        log_size;
  ntt_cmd_t          cmd;
  ntt_stat_t         stat;
  logic [WORD_W-1:0] out_value;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      modulus          <= WORD_W'(998244353);
      mont_neg_inverse <= 32'd998244352;
      log_size         <= 4'd10;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODULUS:  modulus          <= cfg_data[WORD_W-1:0];
        CFG_NEG_INV:  mont_neg_inverse <= cfg_data;
        CFG_LOG_SIZE: log_size         <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  ntt_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .opcode       (opcode),
    .index        (index),
    .log_size     (log_size),
    .stat         (stat),
    .cmd          (cmd),
    .busy         (busy),
    .result_valid (result_valid),
    .kind         (kind)
  );

  ntt_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .stat             (stat),
    .value            (value),
    .modulus          (modulus),
    .mont_neg_inverse (mont_neg_inverse),
    .out_value        (out_value)
  );

  // done words carry zero data
  assign read_value = kind ? '0 : out_value;

endmodule

/* sv/ntt_chk.sv */
// ----------------------------------------------------------------------------
// ntt_chk
// Port-level checks on the command/result sequencing of the NTT block.
// ----------------------------------------------------------------------------
module ntt_chk
  import ntt_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              start,
  input logic              busy,
  input logic [1:0]        opcode,
  input logic              result_valid
);

  // a read or start occupies the block
  a_cmd_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_READ || opcode == OP_START)) |=> busy)
    else $error("busy not raised after read or start");

  // loads never occupy the block
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (opcode == OP_LOAD_COEF || opcode == OP_LOAD_ROOT)) |=> !busy)
    else $error("busy raised after a load");

  // a result word ends the command, so strobes never run together
  a_one_word: assert property (@(posedge clk) disable iff (rst)
    result_valid |=> !result_valid && !busy)
    else $error("result strobe not followed by idle");

  a_word_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> busy)
    else $error("result word outside a command");

  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !busy && !result_valid)
    else $error("block not idle after reset");

endmodule

bind ntt_forward_dif_montgomery ntt_chk u_ntt_chk (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .opcode       (opcode),
  .result_valid (result_valid)
);

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the forward DIF NTT block: loads coefficients and
// roots, starts transforms under several moduli and sizes, reads words back
// and compares every strobed result against a built-in transform predictor.
// ----------------------------------------------------------------------------
module tb_top
  import ntt_pkg::*;
;

  localparam int WATCHDOG_LIMIT = 3000000;
  localparam int DRAIN_CYCLES   = 80;

  typedef struct {
    logic [1:0]        op;
    logic [COEF_AW-1:0] idx;
    logic [WORD_W-1:0] val;
  } cmd_t;

  typedef struct {
    logic              kind;
    logic [WORD_W-1:0] word;
  } result_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         opcode = OP_LOAD_COEF;
  logic [COEF_AW-1:0] index = '0;
  logic [WORD_W-1:0]  value = '0;
  logic               result_valid;
  logic               kind;
  logic [WORD_W-1:0]  read_value;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_MODULUS;
  logic [31:0]        cfg_data = '0;

  // predictor state
  logic [31:0] coef_mem [1 << COEF_AW];
  logic [31:0] root_mem [1 << ROOT_AW];
  logic [29:0] cfg_mod  = 30'd998244353;
  logic [31:0] cfg_ninv = 32'd998244352;
  logic [3:0]  cfg_lg   = 4'd10;

  // generator bookkeeping, so no unwritten entry is ever read
  bit coef_ok [1 << COEF_AW];

  cmd_t    cmd_q [$];
  result_t expected_words [$];
  int      send_idle_pct = 0;
  int      errors = 0;
  int      quiet_cycles = 0;

  ntt_forward_dif_montgomery dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .opcode(opcode), .index(index), .value(value),
    .result_valid(result_valid), .kind(kind), .read_value(read_value),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] mod_reduce(logic [63:0] x);
    if (cfg_mod == 0) return {2'b00, x[29:0]};
    return 32'(x % cfg_mod);
  endfunction

  function automatic logic [31:0] mont_product(logic [31:0] a, logic [31:0] b);
    logic [63:0] prod;
    logic [31:0] m;
    logic [63:0] mp;
    logic [63:0] low;
    prod = 64'(a) * 64'(b);
    m    = prod[31:0] * cfg_ninv;
    mp   = 64'(m) * 64'(cfg_mod);
    low  = 64'(prod[31:0]) + 64'(mp[31:0]);
    return mod_reduce((prod >> 32) + (mp >> 32) + (low >> 32));
  endfunction

  function automatic void run_transform();
    int lg;
    int n;
    int len;
    int j;
    int p;
    int k;
    logic [31:0] w;
    logic [31:0] u;
    logic [31:0] t;
    lg = (cfg_lg > LOG_N_MAX) ? LOG_N_MAX : cfg_lg;
    n  = 1 << lg;
    for (j = 0; j < n; j++) coef_mem[j] = mod_reduce(64'(coef_mem[j]));
    for (len = n >> 1; len >= 1; len >>= 1) begin
      k = 0;
      for (j = 0; j < n; j += 2 * len) begin
        w = mod_reduce(64'(root_mem[k % (1 << ROOT_AW)]));
        for (p = j; p < j + len; p++) begin
          u = coef_mem[p];
          t = mont_product(coef_mem[p + len], w);
          coef_mem[p] = mod_reduce(64'(u) + 64'(t));
          if (cfg_mod == 0) coef_mem[p + len] = {2'b00, 30'(u - t)};
          else coef_mem[p + len] = mod_reduce(64'(u) + 64'(cfg_mod) - 64'(t));
        end
        k++;
      end
    end
  endfunction

  function automatic void predict_word(cmd_t c);
    result_t r;
    case (c.op)
      OP_LOAD_COEF: coef_mem[c.idx] = {2'b00, c.val};
      OP_LOAD_ROOT: root_mem[c.idx[ROOT_AW-1:0]] = {2'b00, c.val};
      OP_START: begin
        run_transform();
        r.kind = 1'b1;
        r.word = '0;
        expected_words.push_back(r);
      end
      default: begin
        r.kind = 1'b0;
        r.word = WORD_W'(mod_reduce(64'(coef_mem[c.idx])));
        expected_words.push_back(r);
      end
    endcase
  endfunction

  task automatic report_mismatch(string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  // driver: predicts each accepted command, one result word per read or start
  always @(posedge clk) begin
    cmd_t c;
    if (rst) begin
      start <= 1'b0;
    end else if (!(start && busy)) begin
      if (start) begin
        c.op = opcode; c.idx = index; c.val = value;
        predict_word(c);
      end
      if (cmd_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        c = cmd_q.pop_front();
        start  <= 1'b1;
        opcode <= c.op;
        index  <= c.idx;
        value  <= c.val;
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t e;
    if (!rst && result_valid) begin
      if (expected_words.size() == 0) begin
        report_mismatch($sformatf("unexpected word kind=%0d value=%0d", kind, read_value));
      end else begin
        e = expected_words.pop_front();
        if (kind !== e.kind)
          report_mismatch($sformatf("kind %0d, want %0d", kind, e.kind));
        if (read_value !== e.word)
          report_mismatch($sformatf("read_value %0d, want %0d", read_value, e.word));
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready) || rst)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog expired");
      $display("** ntt_forward_dif_montgomery: FAILED **");
      $finish;
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_MODULUS: cfg_mod  = data[29:0];
      CFG_NEG_INV: cfg_ninv = data;
      default:     cfg_lg   = data[3:0];
    endcase
  endtask

  function automatic logic [31:0] neg_inverse(logic [31:0] p);
    logic [31:0] inv;
    inv = p;
    repeat (5) inv = inv * (32'd2 - p * inv);
    return -inv;
  endfunction

  task automatic push_cmd(logic [1:0] op, logic [COEF_AW-1:0] idx, logic [WORD_W-1:0] val);
    cmd_t c;
    c.op = op; c.idx = idx; c.val = val;
    cmd_q.push_back(c);
    if (op == OP_LOAD_COEF) coef_ok[idx] = 1'b1;
  endtask

  task automatic push_read(logic [COEF_AW-1:0] idx);
    if (!coef_ok[idx]) push_cmd(OP_LOAD_COEF, idx, WORD_W'($urandom));
    push_cmd(OP_READ, idx, WORD_W'($urandom));
  endtask

  task automatic wait_idle();
    wait (cmd_q.size() == 0 && !start && expected_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // one phase: settings, fresh operands for the active size, random traffic, then a final start and read-back
  task automatic run_phase(logic [29:0] p, logic [31:0] ninv, logic [3:0] lg,
                           int idle, int count);
    int n;
    int roll;
    write_reg(CFG_MODULUS, {2'($urandom), p});
    write_reg(CFG_NEG_INV, ninv);
    write_reg(CFG_LOG_SIZE, {28'($urandom), lg});
    send_idle_pct = idle;
    n = 1 << ((lg > LOG_N_MAX) ? LOG_N_MAX : lg);
    for (int i = 0; i < n; i++) push_cmd(OP_LOAD_COEF, COEF_AW'(i), WORD_W'($urandom));
    for (int i = 0; i < n / 2; i++) push_cmd(OP_LOAD_ROOT, COEF_AW'(i), WORD_W'($urandom));
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(99);
      if (roll < 35)
        push_cmd(OP_LOAD_COEF, ($urandom_range(3) == 0) ? COEF_AW'($urandom)
                 : COEF_AW'($urandom_range(n - 1)), WORD_W'($urandom));
      else if (roll < 45)
        push_cmd(OP_LOAD_ROOT, COEF_AW'($urandom), WORD_W'($urandom));
      else if (roll < 88)
        push_read(($urandom_range(4) == 0) ? COEF_AW'($urandom)
                  : COEF_AW'($urandom_range(n - 1)));
      else
        push_cmd(OP_START, COEF_AW'($urandom), WORD_W'($urandom));
    end
    push_cmd(OP_START, '0, '0);
    for (int i = 0; i < n && i < 16; i++) push_read(COEF_AW'(i));
    wait_idle();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    write_reg(CFG_LOG_SIZE, 32'd3);

    // directed: field extremes, masked root index, high coefficient slot
    for (int i = 0; i < 8; i++) push_cmd(OP_LOAD_COEF, COEF_AW'(i), WORD_W'(i * 7));
    for (int i = 0; i < 4; i++) push_cmd(OP_LOAD_ROOT, COEF_AW'(i), WORD_W'($urandom));
    push_cmd(OP_LOAD_COEF, 10'd0, '0);
    push_cmd(OP_LOAD_COEF, 10'd7, '1);
    push_cmd(OP_LOAD_COEF, 10'd1023, '1);
    push_cmd(OP_LOAD_ROOT, 10'd1023, '1);
    push_cmd(OP_LOAD_ROOT, 10'd513, 30'd998244352);
    push_read(10'd7);
    push_read(10'd1023);
    push_cmd(OP_START, '1, '1);
    for (int i = 0; i < 8; i++) push_read(COEF_AW'(i));
    push_read(10'd1023);
    wait_idle();

    run_phase(30'd998244353, neg_inverse(32'd998244353), 4'd3, 0, 50);
    run_phase(30'd3, neg_inverse(32'd3), 4'd4, 50, 50);
    run_phase(30'd1073741789, neg_inverse(32'd1073741789), 4'd3, 22, 50);
    run_phase(30'd0, $urandom, 4'd1, 0, 50);
    run_phase(30'd998244353, 32'd0, 4'd0, 50, 50);
    run_phase(30'd65537, 32'hFFFF_FFFF, 4'd5, 22, 50);
    run_phase(30'd998244353, 32'd998244352, 4'd2, 50, 50);
    run_phase(30'd12289, neg_inverse(32'd12289), 4'd6, 0, 50);

    if (errors == 0) begin
      $display("** ntt_forward_dif_montgomery: PASSED **");
    end else begin
      $display("** ntt_forward_dif_montgomery: FAILED **");
    end
    $finish;
  end

endmodule

/* ntt_forward_dif_montgomery.f */
sv/ntt_pkg.sv
sv/ntt_rem.sv
sv/ntt_dp.sv
sv/ntt_ctrl.sv
sv/ntt_forward_dif_montgomery.sv
sv/ntt_chk.sv
tb/tb_top.sv
